FILE: src/gbdm_pkg.sv
// gbdm_pkg: shared types and constants for the grid breadth-first distance map
// holds field widths, codes, the sequencer state type and the port structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gbdm_pkg;

	localparam int COORD_W    = 7;
	localparam int COUNT_W    = 8;
	localparam int COUNT_MAX  = 255;
	localparam int DIST_W     = 14;
	localparam int ACT_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	localparam int DEF_MAX_ROWS = 128;
	localparam int DEF_MAX_COLS = 128;

	localparam logic [DIST_W-1:0]  DIST_MAX      = '1;
	localparam logic [COUNT_W-1:0] ROW_COUNT_RST = 8'd128;
	localparam logic [COUNT_W-1:0] COL_COUNT_RST = 8'd128;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD   = 2'd0,
		ACT_SEARCH = 2'd1,
		ACT_READ   = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_COUNT = 2'd0,
		CFG_COL_COUNT = 2'd1,
		CFG_START_ROW = 2'd2,
		CFG_START_COL = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_RIGHT = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_CLEAR,
		ST_SEED,
		ST_POP,
		ST_FETCH,
		ST_NBR,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [COUNT_W-1:0] row_count;
		logic [COUNT_W-1:0] col_count;
		logic [COORD_W-1:0] start_row;
		logic [COORD_W-1:0] start_col;
	} cfg_t;

	typedef struct packed {
		action_t            action;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               is_wall;
	} req_t;

	typedef struct packed {
		logic              out_of_range;
		logic              reached;
		logic [DIST_W-1:0] distance;
	} res_t;

endpackage

`default_nettype wire

FILE: src/gbdm_ram.sv
// gbdm_ram: simple dual-port memory, one write and one registered read a cycle
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module gbdm_ram #(
	parameter int DATA_W = 1,
	parameter int ADDR_W = 14
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: src/gbdm_nbr_step.sv
// gbdm_nbr_step: shared neighbour step unit, one increment/decrement and bound compare
// depends on gbdm_pkg for the direction type and count width
`timescale 1ns / 1ps
`default_nettype none

module gbdm_nbr_step
	import gbdm_pkg::*;
#(
	parameter int RW = 7,
	parameter int CW = 7
) (
	input  wire logic [RW-1:0]      cur_r,
	input  wire logic [CW-1:0]      cur_c,
	input  wire dir_t               dir,
	input  wire logic [COUNT_W-1:0] rows,
	input  wire logic [COUNT_W-1:0] cols,
	output logic      [RW-1:0]      nbr_r,
	output logic      [CW-1:0]      nbr_c,
	output logic                    nbr_ok
);

	localparam int EXT_W = COUNT_W + 1;

	logic             vert;
	logic             dec;
	logic [EXT_W-1:0] opnd;
	logic [EXT_W-1:0] lim;
	logic [EXT_W-1:0] sum;

	always_comb begin
		unique case (dir)
			DIR_UP: begin
				vert = 1'b1;
				dec  = 1'b1;
			end
			DIR_DOWN: begin
				vert = 1'b1;
				dec  = 1'b0;
			end
			DIR_RIGHT: begin
				vert = 1'b0;
				dec  = 1'b0;
			end
			DIR_LEFT: begin
				vert = 1'b0;
				dec  = 1'b1;
			end
		endcase
	end

	assign opnd = vert ? EXT_W'(cur_r) : EXT_W'(cur_c);
	assign lim  = vert ? EXT_W'(rows) : EXT_W'(cols);
	assign sum  = dec ? opnd - 1'b1 : opnd + 1'b1;

	// stepping down from zero leaves the grid, stepping up must stay below the count
	assign nbr_ok = dec ? (opnd != '0) : (sum < lim);
	assign nbr_r  = vert ? RW'(sum) : cur_r;
	assign nbr_c  = vert ? cur_c : CW'(sum);

endmodule

`default_nettype wire

FILE: src/gbdm_engine.sv
// gbdm_engine: item sequencer, cell/wall/queue memories and the search walk
// depends on gbdm_pkg, gbdm_ram and gbdm_nbr_step
`timescale 1ns / 1ps
`default_nettype none

module gbdm_engine
	import gbdm_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic req_valid,
	input  wire req_t req,
	output logic      ready,
	output logic      res_valid,
	output res_t      res
);

	localparam int ROW_LIM = (MAX_ROWS < COUNT_MAX) ? MAX_ROWS : COUNT_MAX;
	localparam int COL_LIM = (MAX_COLS < COUNT_MAX) ? MAX_COLS : COUNT_MAX;
	localparam int RW      = $clog2(ROW_LIM);
	localparam int CW      = $clog2(COL_LIM);
	localparam int AW      = RW + CW;
	localparam int DEPTH   = 2**AW;
	localparam int CELL_W  = DIST_W + 1;
	localparam int QW      = DIST_W + AW;

	state_t state_q, state_d;

	logic [COUNT_W-1:0] rows_eff, cols_eff;
	logic               in_ok, start_ok;
	logic [AW-1:0]      req_addr, start_addr;

	logic [AW-1:0] clr_q;
	logic [AW:0]   head_q, tail_q;
	dir_t          dir_q;
	logic          searched_q;

	logic [AW-1:0]     cur_addr_q;
	logic [DIST_W-1:0] cur_d_q;
	logic [AW-1:0]     nbr_addr_q;
	logic [DIST_W-1:0] next_d;

	logic [RW-1:0] nbr_r;
	logic [CW-1:0] nbr_c;
	logic          nbr_ok;
	logic [AW-1:0] nbr_addr;
	logic          is_new;

	logic              cell_we;
	logic [AW-1:0]     cell_waddr, cell_raddr;
	logic [CELL_W-1:0] cell_wdata, cell_rdata;
	logic              wall_we;
	logic [0:0]        wall_rdata;
	logic              q_we;
	logic [QW-1:0]     q_wdata, q_rdata;

	assign rows_eff = (cfg.row_count > COUNT_W'(ROW_LIM)) ? COUNT_W'(ROW_LIM) : cfg.row_count;
	assign cols_eff = (cfg.col_count > COUNT_W'(COL_LIM)) ? COUNT_W'(COL_LIM) : cfg.col_count;

	assign in_ok    = (COUNT_W'(req.row) < rows_eff) && (COUNT_W'(req.col) < cols_eff);
	assign start_ok = (COUNT_W'(cfg.start_row) < rows_eff) && (COUNT_W'(cfg.start_col) < cols_eff);

	assign req_addr   = {RW'(req.row), CW'(req.col)};
	assign start_addr = {RW'(cfg.start_row), CW'(cfg.start_col)};

	gbdm_nbr_step #(
		.RW(RW),
		.CW(CW)
	) u_nbr_step (
		.cur_r (cur_addr_q[AW-1:CW]),
		.cur_c (cur_addr_q[CW-1:0]),
		.dir   (dir_q),
		.rows  (rows_eff),
		.cols  (cols_eff),
		.nbr_r (nbr_r),
		.nbr_c (nbr_c),
		.nbr_ok(nbr_ok)
	);

	assign nbr_addr = {nbr_r, nbr_c};
	assign next_d   = (cur_d_q == DIST_MAX) ? DIST_MAX : cur_d_q + 1'b1;
	// top bit of a cell entry is its visited mark
	assign is_new   = !cell_rdata[DIST_W] && !wall_rdata[0];

	gbdm_ram #(
		.DATA_W(CELL_W),
		.ADDR_W(AW)
	) u_cell_ram (
		.clk  (clk),
		.we   (cell_we),
		.waddr(cell_waddr),
		.wdata(cell_wdata),
		.raddr(cell_raddr),
		.rdata(cell_rdata)
	);

	gbdm_ram #(
		.DATA_W(1),
		.ADDR_W(AW)
	) u_wall_ram (
		.clk  (clk),
		.we   (wall_we),
		.waddr(req_addr),
		.wdata(req.is_wall),
		.raddr(nbr_addr),
		.rdata(wall_rdata)
	);

	gbdm_ram #(
		.DATA_W(QW),
		.ADDR_W(AW)
	) u_queue_ram (
		.clk  (clk),
		.we   (q_we),
		.waddr(tail_q[AW-1:0]),
		.wdata(q_wdata),
		.raddr(head_q[AW-1:0]),
		.rdata(q_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req.action == ACT_SEARCH) begin
						state_d = ST_CLEAR;
					end else if (req.action == ACT_READ && in_ok) begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ:  state_d = ST_IDLE;
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = ST_SEED;
				end
			end
			ST_SEED:  state_d = start_ok ? ST_POP : ST_DONE;
			ST_POP:   state_d = (head_q == tail_q) ? ST_DONE : ST_FETCH;
			ST_FETCH: state_d = ST_NBR;
			ST_NBR: begin
				if (nbr_ok) begin
					state_d = ST_CHECK;
				end else if (dir_q == DIR_LEFT) begin
					state_d = ST_POP;
				end
			end
			ST_CHECK: state_d = (dir_q == DIR_LEFT) ? ST_POP : ST_NBR;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		ready      = 1'b0;
		res_valid  = 1'b0;
		res        = '0;
		cell_we    = 1'b0;
		cell_waddr = nbr_addr_q;
		cell_wdata = {1'b1, next_d};
		cell_raddr = nbr_addr;
		wall_we    = 1'b0;
		q_we       = 1'b0;
		q_wdata    = {next_d, nbr_addr_q};
		unique case (state_q)
			ST_IDLE: begin
				ready      = 1'b1;
				cell_raddr = req_addr;
				if (req_valid) begin
					unique case (req.action)
						ACT_LOAD: begin
							wall_we          = in_ok;
							res_valid        = 1'b1;
							res.out_of_range = !in_ok;
						end
						ACT_SEARCH: ;
						ACT_READ: begin
							res_valid        = !in_ok;
							res.out_of_range = !in_ok;
						end
						default: res_valid = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				res_valid   = 1'b1;
				res.reached = searched_q && cell_rdata[DIST_W];
				res.distance = res.reached ? cell_rdata[DIST_W-1:0] : '0;
			end
			ST_CLEAR: begin
				cell_we    = 1'b1;
				cell_waddr = clr_q;
				cell_wdata = '0;
			end
			ST_SEED: begin
				cell_we    = start_ok;
				cell_waddr = start_addr;
				cell_wdata = {1'b1, {DIST_W{1'b0}}};
				q_we       = start_ok;
				q_wdata    = {{DIST_W{1'b0}}, start_addr};
			end
			ST_CHECK: begin
				cell_we = is_new;
				q_we    = is_new;
			end
			ST_DONE: begin
				res_valid        = 1'b1;
				res.out_of_range = !start_ok;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			clr_q      <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			dir_q      <= DIR_UP;
			searched_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid && req.action == ACT_SEARCH) begin
						clr_q      <= '0;
						head_q     <= '0;
						tail_q     <= '0;
						searched_q <= 1'b1;
					end
				end
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_SEED: begin
					if (start_ok) begin
						tail_q <= {{AW{1'b0}}, 1'b1};
					end
				end
				ST_POP: begin
					if (head_q != tail_q) begin
						head_q <= head_q + 1'b1;
					end
				end
				ST_FETCH: dir_q <= DIR_UP;
				ST_NBR: begin
					if (!nbr_ok && dir_q != DIR_LEFT) begin
						dir_q <= dir_t'(dir_q + 1'b1);
					end
				end
				ST_CHECK: begin
					if (is_new) begin
						tail_q <= tail_q + 1'b1;
					end
					if (dir_q != DIR_LEFT) begin
						dir_q <= dir_t'(dir_q + 1'b1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH) begin
			{cur_d_q, cur_addr_q} <= q_rdata;
		end
		if (state_q == ST_NBR) begin
			nbr_addr_q <= nbr_addr;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) head_q <= tail_q)
		else $error("queue head passed the tail");

	assert property (@(posedge clk) disable iff (!arst_n) tail_q <= (AW+1)'(DEPTH))
		else $error("queue tail beyond the cell count");

	assert property (@(posedge clk) disable iff (!arst_n) req_valid |-> state_q == ST_IDLE)
		else $error("item taken while a search or read is running");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEED && start_ok) |=> tail_q == {{AW{1'b0}}, 1'b1})
		else $error("origin cell not queued at seed");

endmodule

`default_nettype wire

FILE: src/grid_bfs_distance_map.sv
// Breadth-first distance map over a wall/open grid, taking load, search and read
// beats. Loads, off-grid reads and unknown actions are answered from idle; an on-grid
// read passes through a read state. A search clears the visited store at one cell a
// cycle, all 2**(row bits + column bits) cells, 16384 at the default 128 x 128, then
// walks its queue with one shared neighbour step unit. Neighbours are looked at one at
// a time, each behind a registered memory read, and that sets the pace. No item is
// taken while a read or search runs; configuration must be written
// between items.
// depends on gbdm_pkg and gbdm_engine
`timescale 1ns / 1ps
`default_nettype none

module grid_bfs_distance_map
	import gbdm_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // row, col, is_wall, zero pad
	input  wire logic [ACT_W-1:0]      s_tuser,   // action
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [OUT_DATA_W-1:0] m_tdata    // distance, reached, out_of_range
);

	cfg_t cfg_q;
	req_t req;
	res_t res;
	res_t out_q;
	logic out_valid_q;
	logic eng_ready;
	logic req_valid;
	logic res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_count <= ROW_COUNT_RST;
			cfg_q.col_count <= COL_COUNT_RST;
			cfg_q.start_row <= '0;
			cfg_q.start_col <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ROW_COUNT: cfg_q.row_count <= cfg_data;
				CFG_COL_COUNT: cfg_q.col_count <= cfg_data;
				CFG_START_ROW: cfg_q.start_row <= cfg_data[COORD_W-1:0];
				CFG_START_COL: cfg_q.start_col <= cfg_data[COORD_W-1:0];
			endcase
		end
	end

	assign req.action  = action_t'(s_tuser);
	assign req.row     = s_tdata[COORD_W-1:0];
	assign req.col     = s_tdata[2*COORD_W-1:COORD_W];
	assign req.is_wall = s_tdata[2*COORD_W];

	// a new beat may enter while the held result leaves
	assign s_tready  = eng_ready && (!out_valid_q || m_tready);
	assign req_valid = s_tvalid && s_tready;

	gbdm_engine #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req_valid(req_valid),
		.req      (req),
		.ready    (eng_ready),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.out_of_range, out_q.reached, out_q.distance};

endmodule

`default_nettype wire

FILE: bench/tb.sv
// tb: self-checking bench for grid_bfs_distance_map, streams load, search and read beats
// and predicts every result with its own breadth-first flood of the grid
// depends on gbdm_pkg and the grid_bfs_distance_map top level
`timescale 1ns / 1ps

module tb;
	import gbdm_pkg::*;

	localparam int GRID_ROWS = DEF_MAX_ROWS;
	localparam int GRID_COLS = DEF_MAX_COLS;
	localparam int CELLS = GRID_ROWS * GRID_COLS;
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
	localparam int ITEM_TARGET = 1950;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES = 500;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // row, col, is_wall, zero pad
	logic [ACT_W-1:0]      s_tuser;   // action
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // distance, reached, out_of_range

	class distance_map_scoreboard;
		bit                 wall_bit[CELLS];
		bit                 seen[CELLS];
		logic [DIST_W-1:0]  steps[CELLS];
		logic [COUNT_W-1:0] rows_reg;
		logic [COUNT_W-1:0] cols_reg;
		logic [COORD_W-1:0] org_row;
		logic [COORD_W-1:0] org_col;
		res_t               expected_q[$];
		int                 errors;
		int                 checked;
		int                 reached_hits;

		function new();
			rows_reg = ROW_COUNT_RST;
			cols_reg = COL_COUNT_RST;
			org_row = '0;
			org_col = '0;
			errors = 0;
			checked = 0;
			reached_hits = 0;
		endfunction

		function int eff_rows();
			return (rows_reg > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
		endfunction

		function int eff_cols();
			return (cols_reg > GRID_COLS) ? GRID_COLS : int'(cols_reg);
		endfunction

		function bit on_grid(int r, int c);
			return (r < eff_rows()) && (c < eff_cols());
		endfunction

		function void set_reg(cfg_reg_t idx, int v);
			case (idx)
			CFG_ROW_COUNT: rows_reg = v[COUNT_W-1:0];
			CFG_COL_COUNT: cols_reg = v[COUNT_W-1:0];
			CFG_START_ROW: org_row = v[COORD_W-1:0];
			CFG_START_COL: org_col = v[COORD_W-1:0];
			default: ;
			endcase
		endfunction

		function void flood_from_origin();
			int                fifo[$];
			int                cur, r, c, nr, nc, ni, nrows, ncols;
			logic [DIST_W-1:0] d;
			nrows = eff_rows();
			ncols = eff_cols();
			foreach (seen[i])
				seen[i] = 1'b0;
			if (!on_grid(org_row, org_col))
				return;
			ni = org_row * GRID_COLS + org_col;
			seen[ni] = 1'b1;
			steps[ni] = '0;
			fifo = {fifo, ni};
			while (fifo.size() > 0) begin
				cur = fifo.pop_front();
				r = cur / GRID_COLS;
				c = cur % GRID_COLS;
				d = steps[cur];
				for (int k = 0; k < 4; k++) begin
					nr = r;
					nc = c;
					case (dir_t'(k))
					DIR_UP:    nr = r - 1;
					DIR_DOWN:  nr = r + 1;
					DIR_RIGHT: nc = c + 1;
					DIR_LEFT:  nc = c - 1;
					endcase
					if (nr < 0 || nc < 0 || nr >= nrows || nc >= ncols)
						continue;
					ni = nr * GRID_COLS + nc;
					if (seen[ni] || wall_bit[ni])
						continue;
					seen[ni] = 1'b1;
					steps[ni] = (d == DIST_MAX) ? DIST_MAX : d + 1'b1;
					fifo = {fifo, ni};
				end
			end
		endfunction

		function void note_item(logic [ACT_W-1:0] act, int r, int c, bit w);
			res_t want;
			bit   fits;
			int   slot;
			want = '0;
			fits = on_grid(r, c);
			slot = r * GRID_COLS + c;
			case (act)
			ACT_LOAD: begin
				if (fits)
					wall_bit[slot] = w;
				want.out_of_range = !fits;
			end
			ACT_SEARCH: begin
				flood_from_origin();
				want.out_of_range = !on_grid(org_row, org_col);
			end
			ACT_READ: begin
				if (!fits) begin
					want.out_of_range = 1'b1;
				end else if (seen[slot]) begin
					want.reached = 1'b1;
					want.distance = steps[slot];
				end
			end
			default: ;
			endcase
			expected_q = {expected_q, want};
		endfunction

		function void check_beat(logic [OUT_DATA_W-1:0] beat);
			res_t got, want;
			got = beat;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result beat %h with nothing expected", $time, beat);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (want.reached)
				reached_hits++;
			if (got.distance !== want.distance) begin
				errors++;
				$display("%0t: distance mismatch, expected %0d, actual %0d",
					$time, want.distance, got.distance);
			end
			if (got.reached !== want.reached) begin
				errors++;
				$display("%0t: reached mismatch, expected %0b, actual %0b",
					$time, want.reached, got.reached);
			end
			if (got.out_of_range !== want.out_of_range) begin
				errors++;
				$display("%0t: out_of_range mismatch, expected %0b, actual %0b",
					$time, want.out_of_range, got.out_of_range);
			end
		endfunction
	endclass

	distance_map_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int items_sent;
	int searches_sent;
	int phases_run;
	int cycle_count;

	grid_bfs_distance_map dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped after %0d cycles with %0d results outstanding",
			cycle_count, sb.expected_q.size());
		$display("grid_bfs_distance_map regression: fail");
		$finish;
	end

	// result side: checks accepted beats, then picks tready for the next edge
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_beat(m_tdata);
			if (hold_request > 0) begin
				hold_request--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_beat(logic [ACT_W-1:0] act, int r, int c, bit w);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {1'b0, w, c[COORD_W-1:0], r[COORD_W-1:0]};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_item(act, r, c, w);
		items_sent++;
		if (act == ACT_SEARCH)
			searches_sent++;
	endtask

	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_grid(int rows, int cols, int sr, int sc);
		int vals[4];
		vals = '{rows, cols, sr, sc};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= vals[i][CFG_DATA_W-1:0];
			@(posedge clk);
			sb.set_reg(cfg_reg_t'(i), vals[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_idle_mode(int mode);
		case (mode)
		0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
		1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
		2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
		default: begin send_idle_pct = 38; recv_stall_pct = 38; end
		endcase
	endtask

	// any coordinates, any action but search; mostly lands off a small grid
	task automatic random_noise_item();
		int pick;
		logic [ACT_W-1:0] act;
		pick = $urandom_range(2);
		act = (pick == 0) ? ACT_LOAD : (pick == 1) ? ACT_READ : ACT_NONE;
		send_beat(act, $urandom_range(127), $urandom_range(127), 1'($urandom_range(1)));
	endtask

	task automatic directed_checks();
		// defaults straight after reset: nothing searched yet
		send_beat(ACT_READ, 0, 0, 1'b0);
		send_beat(ACT_READ, 127, 127, 1'b1);
		settle_block();
		set_grid(3, 4, 1, 2);
		send_beat(ACT_LOAD, 127, 127, 1'b1);
		// diagonal walls, origin itself sits on a wall
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 4; c++)
				send_beat(ACT_LOAD, r, c, ((r + c) % 3) == 0);
		send_beat(ACT_NONE, 127, 127, 1'b1);
		send_beat(ACT_SEARCH, 0, 0, 1'b0);
		send_beat(ACT_READ, 1, 2, 1'b0);
		send_beat(ACT_READ, 2, 0, 1'b0);
		send_beat(ACT_READ, 0, 0, 1'b0);
		send_beat(ACT_READ, 127, 0, 1'b0);
		settle_block();
		// zero rows: every cell off the grid, origin included
		set_grid(0, 5, 127, 127);
		send_beat(ACT_SEARCH, 127, 127, 1'b1);
		send_beat(ACT_READ, 0, 0, 1'b0);
	endtask

	task automatic run_phase(int p);
		int rows, cols, er, ec, sr, sc, shape, reads, pick;
		shape = $urandom_range(9);
		if (shape == 0) begin
			rows = $urandom_range(1) ? 128 : $urandom_range(129, 255);
			cols = 1;
		end else if (shape == 1) begin
			rows = 1;
			cols = $urandom_range(1) ? 128 : $urandom_range(129, 255);
		end else begin
			rows = $urandom_range(1, 12);
			cols = $urandom_range(1, 12);
		end
		er = (rows > GRID_ROWS) ? GRID_ROWS : rows;
		ec = (cols > GRID_COLS) ? GRID_COLS : cols;
		if ($urandom_range(7) == 0) begin
			sr = $urandom_range(127);
			sc = $urandom_range(127);
		end else begin
			sr = $urandom_range(er - 1);
			sc = $urandom_range(ec - 1);
		end
		settle_block();
		set_idle_mode(p % 4);
		set_grid(rows, cols, sr, sc);
		if (p == 0)
			hold_request = HOLD_CYCLES;
		// every wall bit of the grid is written before the first search
		for (int i = 0; i < er * ec; i++) begin
			if ($urandom_range(9) == 0)
				random_noise_item();
			send_beat(ACT_LOAD, i / ec, i % ec, $urandom_range(99) < 28);
		end
		for (int sweep = 0; sweep < 2; sweep++) begin
			send_beat(ACT_SEARCH, $urandom_range(127), $urandom_range(127),
				1'($urandom_range(1)));
			reads = $urandom_range(25, 45);
			for (int k = 0; k < reads; k++) begin
				pick = $urandom_range(99);
				if (pick < 75)
					send_beat(ACT_READ, $urandom_range(er - 1), $urandom_range(ec - 1),
						1'($urandom_range(1)));
				else if (pick < 85)
					send_beat(ACT_LOAD, $urandom_range(er - 1), $urandom_range(ec - 1),
						1'($urandom_range(1)));
				else
					random_noise_item();
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ROW_COUNT;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_LOAD;
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		items_sent = 0;
		searches_sent = 0;
		phases_run = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_checks();
		while (items_sent < ITEM_TARGET) begin
			run_phase(phases_run);
			phases_run++;
		end
		settle_block();
		$display("covered %0d beats over %0d grid settings, %0d searches, in %0d cycles",
			items_sent, phases_run, searches_sent, cycle_count);
		$display("%0d results checked, %0d reads hit a reached cell, %0d mismatches",
			sb.checked, sb.reached_hits, sb.errors);
		if (sb.errors == 0)
			$display("grid_bfs_distance_map regression: pass");
		else
			$display("grid_bfs_distance_map regression: fail");
		$finish;
	end

endmodule
